@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the span table.
// Depends on nothing; taken in by sorted_span_table.sv, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/sst_pkg.sv @@
// Types and codes for the sorted span table.
// Depends on nothing; used by the RAM-based table logic.
package sst_pkg;

  // Operation codes carried on the kind field.
  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_FIND = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SPAN = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] len;
  } span_t;

endpackage

@@ hw/rtl/sst_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sorted_span_table.sv @@
// Sorted span table: one command at a time, result strobed on done for one cycle.
// Find, add and delete scan the table at one entry per cycle, then shift entries
// one per cycle through the RAM port for inserts and removals; a read skips the scan.
// busy stays high until done, so the next command can be taken in the done cycle;
// the receiver cannot stall. Synchronous reset empties the table at once.
`include "assert_macros.svh"

module sorted_span_table #(
  parameter int MAX_SPANS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [63:0] address,
  input  logic [63:0] length,
  input  logic [5:0]  index,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic        found,
  output logic [63:0] span_base,
  output logic [63:0] span_length,
  output logic [6:0]  entries_used
);

  localparam int AW = $clog2(MAX_SPANS);
  localparam int CW = $clog2(MAX_SPANS + 1);
  localparam int SW = $bits(sst_pkg::span_t);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_NXT, S_DEC, S_SHIFT, S_RDW, S_FIN
  } state_t;

  typedef enum logic [1:0] {ACT_FIN, ACT_SHR, ACT_SHL} act_t;

  typedef struct packed {
    act_t           act;
    logic           wr;
    sst_pkg::span_t wspan;
    logic [1:0]     status;
    logic           found;
    sst_pkg::span_t rspan;
    logic [AW-1:0]  pos;
    sst_pkg::span_t ispan;
  } dec_t;

  state_t          state;
  sst_pkg::kind_t  op;
  logic [63:0]     a;
  logic [63:0]     n;
  logic [64:0]     top;
  logic [CW-1:0]   total;
  logic [AW-1:0]   cnt;
  logic            hit;
  logic [AW-1:0]   hit_i;
  sst_pkg::span_t  ent;
  sst_pkg::span_t  nxt;
  logic            has_next;
  logic [64:0]     e_end;
  logic [64:0]     s_sum;
  logic [AW-1:0]   rp;
  logic [AW-1:0]   wp;
  logic [CW-1:0]   rem;
  logic            pend;
  logic            dir_up;
  logic [AW-1:0]   ins_pos;
  sst_pkg::span_t  ins_span;
  logic [1:0]      res_status;
  logic            res_found;
  sst_pkg::span_t  res_span;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [SW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [SW-1:0]   ram_rdata;
  sst_pkg::span_t  rspan_q;

  dec_t            dec;
  logic [64:0]     a65;
  logic [64:0]     scan_end;
  logic            scan_hit;
  logic [CW-1:0]   cnt_next;
  logic [CW+6:0]   tot_ext;

  assign busy     = (state != S_IDLE);
  assign rspan_q  = sst_pkg::span_t'(ram_rdata);
  assign a65      = {1'b0, a};
  assign cnt_next = CW'(cnt) + CW'(1);
  assign tot_ext  = (CW + 7)'(total);

  // Entry storage.
  sst_ram #(.WIDTH(SW), .DEPTH(MAX_SPANS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan compare on the entry that just came out of the RAM.
  always_comb begin
    scan_end = {1'b0, rspan_q.base} + {1'b0, rspan_q.len};
    if (op == sst_pkg::KIND_ADD) begin
      scan_hit = !(a65 > scan_end);
    end else begin
      scan_hit = (a >= rspan_q.base) && (scan_end > a65);
    end
  end

  // Decision on the hit entry and its successor.
  always_comb begin
    logic [64:0] t_sum;
    logic [64:0] eb65;
    logic [64:0] nb65;
    logic        full;
    t_sum = {1'b0, s_sum[63:0]} + {1'b0, nxt.len};
    eb65  = {1'b0, ent.base};
    nb65  = {1'b0, nxt.base};
    full  = (total == CW'(MAX_SPANS));
    dec        = '0;
    dec.act    = ACT_FIN;
    dec.status = sst_pkg::STAT_OK;
    dec.pos    = hit_i;
    case (op)
      sst_pkg::KIND_ADD: begin
        if (full) begin
          dec.status = sst_pkg::STAT_FULL;
        end else if (top[64] && (top[63:0] != 64'd0)) begin
          dec.status = sst_pkg::STAT_SPAN;
        end else if (!hit) begin
          dec.act   = ACT_SHR;
          dec.pos   = AW'(total);
          dec.ispan = '{base: a, len: n};
        end else if (top == eb65) begin
          // New span sits right in front of the entry.
          if (s_sum[64]) begin
            dec.status = sst_pkg::STAT_SPAN;
          end else begin
            dec.wr    = 1'b1;
            dec.wspan = '{base: a, len: s_sum[63:0]};
          end
        end else if (a65 == e_end) begin
          // New span follows the entry, and may bridge to the next one.
          if (has_next && (top > nb65)) begin
            dec.status = sst_pkg::STAT_SPAN;
          end else if (has_next && (top == nb65)) begin
            if (s_sum[64] || t_sum[64]) begin
              dec.status = sst_pkg::STAT_SPAN;
            end else begin
              dec.wr    = 1'b1;
              dec.wspan = '{base: ent.base, len: t_sum[63:0]};
              dec.act   = ACT_SHL;
              dec.pos   = hit_i + AW'(1);
            end
          end else if (s_sum[64]) begin
            dec.status = sst_pkg::STAT_SPAN;
          end else begin
            dec.wr    = 1'b1;
            dec.wspan = '{base: ent.base, len: s_sum[63:0]};
          end
        end else if (top > eb65) begin
          dec.status = sst_pkg::STAT_SPAN;
        end else begin
          dec.act   = ACT_SHR;
          dec.ispan = '{base: a, len: n};
        end
      end
      sst_pkg::KIND_DEL: begin
        if (!hit || (top > e_end)) begin
          dec.status = sst_pkg::STAT_SPAN;
        end else if (a == ent.base) begin
          if (n == ent.len) begin
            dec.act = ACT_SHL;
          end else begin
            dec.wr    = 1'b1;
            dec.wspan = '{base: top[63:0], len: ent.len - n};
          end
        end else if (top == e_end) begin
          dec.wr    = 1'b1;
          dec.wspan = '{base: ent.base, len: ent.len - n};
        end else if (full) begin
          dec.status = sst_pkg::STAT_FULL;
        end else begin
          // Split: keep the head here, insert the tail behind it.
          dec.wr    = 1'b1;
          dec.wspan = '{base: ent.base, len: a - ent.base};
          dec.act   = ACT_SHR;
          dec.pos   = hit_i + AW'(1);
          dec.ispan = '{base: top[63:0], len: e_end[63:0] - top[63:0]};
        end
      end
      sst_pkg::KIND_FIND: begin
        dec.found = hit;
        if (hit) begin
          dec.rspan = ent;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_i;
    ram_wdata = dec.wspan;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (sst_pkg::kind_t'(kind) == sst_pkg::KIND_READ) begin
          ram_raddr = AW'(index);
        end
      end
      S_SCAN: begin
        ram_raddr = cnt + AW'(1);
      end
      S_DEC: begin
        ram_we = dec.wr;
      end
      S_SHIFT: begin
        ram_raddr = rp;
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = wp;
          ram_wdata = ram_rdata;
        end else if ((rem == '0) && dir_up) begin
          ram_we    = 1'b1;
          ram_waddr = ins_pos;
          ram_wdata = ins_span;
        end
      end
      default: begin
      end
    endcase
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op         <= sst_pkg::kind_t'(kind);
            a          <= address;
            n          <= length;
            top        <= {1'b0, address} + {1'b0, length};
            res_status <= sst_pkg::STAT_OK;
            res_found  <= 1'b0;
            res_span   <= '0;
            hit        <= 1'b0;
            has_next   <= 1'b0;
            cnt        <= '0;
            if (sst_pkg::kind_t'(kind) == sst_pkg::KIND_READ) begin
              if (32'(index) < 32'(total)) begin
                state <= S_RDW;
              end else begin
                state <= S_FIN;
              end
            end else if (total == '0) begin
              state <= S_DEC;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            hit      <= 1'b1;
            hit_i    <= cnt;
            ent      <= rspan_q;
            e_end    <= scan_end;
            s_sum    <= {1'b0, rspan_q.len} + {1'b0, n};
            has_next <= (cnt_next < total);
            state    <= S_NXT;
          end else if (cnt_next == total) begin
            state <= S_DEC;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_NXT: begin
          nxt   <= rspan_q;
          state <= S_DEC;
        end
        S_DEC: begin
          res_status <= dec.status;
          res_found  <= dec.found;
          res_span   <= dec.rspan;
          pend       <= 1'b0;
          ins_pos    <= dec.pos;
          ins_span   <= dec.ispan;
          case (dec.act)
            ACT_SHR: begin
              rp     <= AW'(total - CW'(1));
              wp     <= AW'(total);
              rem    <= total - CW'(dec.pos);
              dir_up <= 1'b1;
              state  <= S_SHIFT;
            end
            ACT_SHL: begin
              rp     <= dec.pos + AW'(1);
              wp     <= dec.pos;
              rem    <= total - CW'(1) - CW'(dec.pos);
              dir_up <= 1'b0;
              state  <= S_SHIFT;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_SHIFT: begin
          if (pend) begin
            wp <= dir_up ? wp - AW'(1) : wp + AW'(1);
          end
          if (rem != '0) begin
            rp   <= dir_up ? rp - AW'(1) : rp + AW'(1);
            rem  <= rem - CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (!pend && (rem == '0)) begin
            total <= dir_up ? total + CW'(1) : total - CW'(1);
            state <= S_FIN;
          end
        end
        S_RDW: begin
          res_found <= 1'b1;
          res_span  <= rspan_q;
          state     <= S_FIN;
        end
        S_FIN: begin
          done         <= 1'b1;
          status       <= res_status;
          found        <= res_found;
          span_base    <= res_span.base;
          span_length  <= res_span.len;
          entries_used <= tot_ext[6:0];
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the entry count.
  `SST_ASSERT_IMPL(a_total_range, clk, rst, 1'b1, total <= CW'(MAX_SPANS))
  `SST_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `SST_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

endmodule
